FILE: rtl/bol_pkg.sv
// Shared types and constants for the bounded ordered list core.
`timescale 1ns / 1ps

package bol_pkg;

    localparam int LIST_CAPACITY = 16;
    localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);
    localparam int IDX_W         = $clog2(LIST_CAPACITY);
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 8;
    localparam int OUT_IDX_W     = 6;
    localparam int SIZE_W        = 7;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK   = 3'd0,
        REQ_PUSH_FRONT  = 3'd1,
        REQ_POP_FRONT   = 3'd2,
        REQ_POP_BACK    = 3'd3,
        REQ_INSERT      = 3'd4,
        REQ_REMOVE_LAST = 3'd5,
        REQ_DUMP        = 3'd6
    } req_type_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Source that a cell loads on the next clock.
    typedef enum logic [2:0] {
        SEL_HOLD  = 3'd0,
        SEL_LEFT  = 3'd1,
        SEL_RIGHT = 3'd2,
        SEL_NEW   = 3'd3,
        SEL_HEAD  = 3'd4
    } cell_sel_t;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          remove_count;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [OUT_IDX_W-1:0]      out_index;
        logic [SIZE_W-1:0]         list_size;
        logic [1:0]                status;
        logic                      last_flag;
    } rsp_t;

endpackage

FILE: rtl/bounded_ordered_list_core.sv
// Top level of the bounded ordered list: request sequencer and the row of cells.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | bol_pkg::req_t (type, value, position, count)
//   rsp     | out       | rsp_valid/stall  | bol_pkg::rsp_t (value, index, size, status, last)
//
// A request is registered while idle and executed in the exec state, which waits
// while the response is stalled. A dump emits its entries through the head cell,
// since the row of cells rotates by one place for each entry it emits. Reset clears
// the sequencer, the entry count and the output valid; cell contents are not reset.
// A stalled response holds the sequencer until the output frees up.
`timescale 1ns / 1ps

module bounded_ordered_list_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bol_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bol_pkg::rsp_t rsp
);
    import bol_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              can_emit;
    logic              is_full;
    logic              is_empty;
    logic              dump_last;
    logic [CNT_W-1:0]  last_pos;
    logic [CNT_W-1:0]  ins_pos;
    logic              emit;
    status_t           status;

    logic signed [VALUE_W-1:0] cell_val   [LIST_CAPACITY];
    logic signed [VALUE_W-1:0] left_val   [LIST_CAPACITY];
    logic signed [VALUE_W-1:0] right_val  [LIST_CAPACITY];
    cell_sel_t                 cell_sel   [LIST_CAPACITY];

    assign req_stall = (state_reg != S_IDLE);
    assign can_emit  = !rsp_valid_reg || !rsp_stall;
    assign is_full   = (count_reg == CNT_W'(LIST_CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign last_pos  = count_reg - CNT_W'(1);
    assign dump_last = (CNT_W'(idx_reg) == last_pos);

    always_comb
    begin
        unique case (req_type_t'(req_reg.req_type)) inside
            REQ_PUSH_BACK:  ins_pos = count_reg;
            REQ_PUSH_FRONT: ins_pos = '0;
            default:
            begin
                if (req_reg.position >= POS_W'(count_reg))
                    ins_pos = count_reg;
                else
                    ins_pos = CNT_W'(req_reg.position);
            end
        endcase
    end

    // The cells form a ring; the wrap-around links are only used on slots
    // that hold no entry.
    always_comb
    begin
        for (int i = 0; i < LIST_CAPACITY; i++)
        begin
            left_val[i]  = cell_val[(i + LIST_CAPACITY - 1) % LIST_CAPACITY];
            right_val[i] = cell_val[(i + 1) % LIST_CAPACITY];
        end
    end

    always_comb
    begin
        for (int i = 0; i < LIST_CAPACITY; i++)
        begin
            cell_sel[i] = SEL_HOLD;
            if (state_reg == S_EXEC && can_emit)
            begin
                unique case (req_type_t'(req_reg.req_type)) inside
                    REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT:
                    begin
                        if (!is_full)
                        begin
                            if (CNT_W'(i) == ins_pos)
                                cell_sel[i] = SEL_NEW;
                            else if (CNT_W'(i) > ins_pos)
                                cell_sel[i] = SEL_LEFT;
                        end
                    end
                    REQ_POP_FRONT:
                    begin
                        if (!is_empty)
                            cell_sel[i] = SEL_RIGHT;
                    end
                    default: cell_sel[i] = SEL_HOLD;
                endcase
            end
            else if (state_reg == S_DUMP && can_emit)
            begin
                // Rotate the occupied cells left by one; the head wraps to the tail.
                if (CNT_W'(i) == last_pos)
                    cell_sel[i] = SEL_HEAD;
                else if (CNT_W'(i) < last_pos)
                    cell_sel[i] = SEL_RIGHT;
            end
        end
    end

    for (genvar g = 0; g < LIST_CAPACITY; g++)
    begin : g_cell
        bol_cell u_cell (
            .clk       (clk),
            .sel       (cell_sel[g]),
            .left_val  (left_val[g]),
            .right_val (right_val[g]),
            .new_val   (req_reg.item_value),
            .head_val  (cell_val[0]),
            .val       (cell_val[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        emit           = 1'b0;
        status         = ST_DONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    unique case (req_type_t'(req_reg.req_type)) inside
                        REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT:
                        begin
                            if (is_full)
                                status = ST_FULL;
                            else
                                count_next = count_reg + CNT_W'(1);
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            if (is_empty)
                                status = ST_EMPTY;
                            else
                                count_next = count_reg - CNT_W'(1);
                        end
                        REQ_REMOVE_LAST:
                        begin
                            if (is_empty)
                                status = ST_EMPTY;
                            else if (req_reg.remove_count >= POS_W'(count_reg))
                                count_next = '0;
                            else
                                count_next = count_reg - CNT_W'(req_reg.remove_count);
                        end
                        REQ_DUMP:
                        begin
                            if (is_empty)
                                status = ST_EMPTY;
                            else
                            begin
                                emit       = 1'b0;
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: status = ST_DONE;
                    endcase
                    if (emit)
                    begin
                        rsp_valid_next     = 1'b1;
                        rsp_next.out_value = '0;
                        rsp_next.out_index = '0;
                        rsp_next.list_size = SIZE_W'(count_next);
                        rsp_next.status    = status;
                        rsp_next.last_flag = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
            end
            S_DUMP:
            begin
                if (can_emit)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.out_value = cell_val[0];
                    rsp_next.out_index = OUT_IDX_W'(idx_reg);
                    rsp_next.list_size = SIZE_W'(count_reg);
                    rsp_next.status    = ST_DONE;
                    rsp_next.last_flag = dump_last;
                    idx_next           = idx_reg + IDX_W'(1);
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/bol_cell.sv
// One storage cell of the list, loading from a neighbor, a new value or the head.
`timescale 1ns / 1ps

module bol_cell (
    input  logic                               clk,
    input  bol_pkg::cell_sel_t                 sel,
    input  logic signed [bol_pkg::VALUE_W-1:0] left_val,
    input  logic signed [bol_pkg::VALUE_W-1:0] right_val,
    input  logic signed [bol_pkg::VALUE_W-1:0] new_val,
    input  logic signed [bol_pkg::VALUE_W-1:0] head_val,
    output logic signed [bol_pkg::VALUE_W-1:0] val
);
    import bol_pkg::*;

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;

    always_comb
    begin
        case (sel)
            SEL_LEFT:  val_next = left_val;
            SEL_RIGHT: val_next = right_val;
            SEL_NEW:   val_next = new_val;
            SEL_HEAD:  val_next = head_val;
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

FILE: rtl/bol_checker.sv
// Port-level checks for the bounded ordered list core, bound to the top level.
`timescale 1ns / 1ps

module bol_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input bol_pkg::rsp_t rsp
);
    import bol_pkg::*;

    // A taken request keeps the input stalled while it executes.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request input open right after a request was taken");

    // A stalled response must hold until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.list_size <= SIZE_W'(LIST_CAPACITY))
        else $error("list size beyond capacity");

    // A full or empty status ends its request and reports a matching size.
    a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |->
            rsp.last_flag && rsp.list_size == SIZE_W'(LIST_CAPACITY))
        else $error("full status with list not full");

    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |->
            rsp.last_flag && rsp.list_size == '0 && rsp.out_value == '0)
        else $error("empty status with entries present");

endmodule

bind bounded_ordered_list_core bol_checker u_bol_checker (.*);
